@@ hdl/dehs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_pkg
// Shared types and constants for the debounced edge homing sequencer.
// ----------------------------------------------------------------------------
package dehs_pkg;

    // switch lanes: spare, rod, barrier
    localparam int NSW = 3;
    localparam int LANE_SPARE   = 0;
    localparam int LANE_ROD     = 1;
    localparam int LANE_BARRIER = 2;

    // port bit of each switch lane
    localparam logic [2:0] SW_BIT [NSW] = '{3'd2, 3'd3, 3'd4};

    localparam int PORT_W    = 8;
    localparam int LOCKOUT_W = 10;
    localparam int ELAPSED_W = 16;
    localparam int CFG_W     = 16;

    localparam logic [PORT_W-1:0]    PORT_RESET    = 8'hFF;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 10'd20;
    localparam logic [ELAPSED_W-1:0] HOMING_RESET  = 16'd2000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    // action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_STEP   = 2'd2;

    // actuator command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_DRIVE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_LOCKOUT = 1'b0;
    localparam logic CFG_HOMING  = 1'b1;

    // decoded request going into the state units
    typedef struct packed {
        logic              sample;
        logic              tick;
        logic              step;
        logic [PORT_W-1:0] port;
    } t_ctl;

    // homing unit result
    typedef struct packed {
        logic [1:0]           arm;
        logic [1:0]           bar;
        logic [1:0]           rod;
        logic                 running;
        logic [ELAPSED_W-1:0] elapsed;
    } t_res;

endpackage
`default_nettype wire

@@ hdl/dehs_switch.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_switch
// Falling edge detection with per-switch lockout timers and sticky flags.
// ----------------------------------------------------------------------------
module dehs_switch
    import dehs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl                 i_ctl,
    input  wire logic [LOCKOUT_W-1:0] i_lockout_ms,
    output logic      [NSW-1:0]       o_edge_seen,
    output logic      [NSW-1:0]       o_edge_next
);

    logic [PORT_W-1:0]    r_prev, n_prev;
    logic [NSW-1:0]       r_edge, n_edge;
    logic [NSW-1:0]       r_act, n_act;
    logic [LOCKOUT_W-1:0] r_cnt [NSW];
    logic [LOCKOUT_W-1:0] n_cnt [NSW];

    // per-lane edge capture and lockout countdown
    always_comb begin
        logic [LOCKOUT_W-1:0] v_inc;
        n_prev = r_prev;
        n_edge = r_edge;
        n_act  = r_act;
        v_inc  = '0;
        for (int i = 0; i < NSW; i++) begin
            n_cnt[i] = r_cnt[i];
            if (i_ctl.sample) begin
                if (!i_ctl.port[SW_BIT[i]] && r_prev[SW_BIT[i]] && !r_act[i]) begin
                    n_edge[i] = 1'b1;
                    n_act[i]  = 1'b1;
                    n_cnt[i]  = '0;
                end
            end
            if (i_ctl.tick && r_act[i]) begin
                v_inc = r_cnt[i] + LOCKOUT_W'(1);
                if (v_inc >= i_lockout_ms) begin
                    n_act[i] = 1'b0;
                    n_cnt[i] = '0;
                end else begin
                    n_cnt[i] = v_inc;
                end
            end
        end
        if (i_ctl.sample) begin
            n_prev = i_ctl.port;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= PORT_RESET;
            r_edge <= '0;
            r_act  <= '0;
            for (int i = 0; i < NSW; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_prev <= n_prev;
            r_edge <= n_edge;
            r_act  <= n_act;
            for (int i = 0; i < NSW; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    assign o_edge_seen = r_edge;
    assign o_edge_next = n_edge;

endmodule
`default_nettype wire

@@ hdl/dehs_homing.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dehs_homing
// Homing step sequencing and saturating elapsed tick counter.
// ----------------------------------------------------------------------------
module dehs_homing
    import dehs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl                 i_ctl,
    input  wire logic [ELAPSED_W-1:0] i_homing_ms,
    input  wire logic [NSW-1:0]       i_edge_seen,
    output t_res                      o_res
);

    logic                 r_en, n_en;
    logic [ELAPSED_W-1:0] r_el, n_el;
    logic [1:0]           w_arm, w_bar, w_rod;

    // counter update and command selection
    always_comb begin
        n_en  = r_en;
        n_el  = r_el;
        w_arm = CMD_NONE;
        w_bar = CMD_NONE;
        w_rod = CMD_NONE;
        if (i_ctl.tick && r_en && (r_el != ELAPSED_MAX)) begin
            n_el = r_el + ELAPSED_W'(1);
        end
        if (i_ctl.step) begin
            n_en = 1'b1;
            if (r_el < i_homing_ms) begin
                w_arm = CMD_DRIVE;
                w_bar = CMD_DRIVE;
                // barrier home: stop it and raise the rod until its edge
                if (i_edge_seen[LANE_BARRIER]) begin
                    w_bar = CMD_STOP;
                    w_rod = i_edge_seen[LANE_ROD] ? CMD_STOP : CMD_DRIVE;
                end
            end else begin
                w_arm = CMD_STOP;
                n_el  = '0;
                n_en  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_el <= '0;
        end else begin
            r_en <= n_en;
            r_el <= n_el;
        end
    end

    assign o_res = '{arm: w_arm, bar: w_bar, rod: w_rod, running: n_en, elapsed: n_el};

endmodule
`default_nettype wire

@@ hdl/debounced_edge_homing_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_edge_homing_sequencer
// Limit switch edge debounce with lockout timers and a timed homing sequence.
// ----------------------------------------------------------------------------
// flow: a request is held in the input register, then its result in the result
// register; throughput: one request per cycle while the result channel does not
// stall, the state update between the two registers being combinational
// reset: synchronous active low; port history all ones, flags, timers and
// counter cleared, lockout_ms 20, homing_ms 2000
module debounced_edge_homing_sequencer
    import dehs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_action,
    input  wire logic [PORT_W-1:0]    i_port_value,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [1:0]           o_arm_cmd,
    output logic      [1:0]           o_barrier_cmd,
    output logic      [1:0]           o_rod_cmd,
    output logic      [NSW-1:0]       o_edge_flags,
    output logic                      o_homing_running,
    output logic      [ELAPSED_W-1:0] o_elapsed_ms,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic                 r_s1_vld;
    logic [1:0]           r_s1_action;
    logic [PORT_W-1:0]    r_s1_port;
    logic                 r_out_vld;
    logic [LOCKOUT_W-1:0] r_lockout_ms;
    logic [ELAPSED_W-1:0] r_homing_ms;
    logic                 w_adv;
    logic                 w_fire;
    t_ctl                 w_ctl;
    logic [NSW-1:0]       w_edge_seen;
    logic [NSW-1:0]       w_edge_next;
    t_res                 w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ms <= LOCKOUT_RESET;
            r_homing_ms  <= HOMING_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCKOUT: r_lockout_ms <= i_cfg_data[LOCKOUT_W-1:0];
                CFG_HOMING:  r_homing_ms  <= i_cfg_data[ELAPSED_W-1:0];
                default:     ;
            endcase
        end
    end

    // pipeline flow control
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !w_adv;
    assign w_fire     = r_s1_vld && w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_action <= i_action;
            r_s1_port   <= i_port_value;
        end
    end

    // action decode
    always_comb begin
        w_ctl      = '0;
        w_ctl.port = r_s1_port;
        unique case (r_s1_action)
            ACT_SAMPLE: w_ctl.sample = w_fire;
            ACT_TICK:   w_ctl.tick   = w_fire;
            ACT_STEP:   w_ctl.step   = w_fire;
            default:    ;
        endcase
    end

    dehs_switch u_switch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_lockout_ms (r_lockout_ms),
        .o_edge_seen  (w_edge_seen),
        .o_edge_next  (w_edge_next)
    );

    dehs_homing u_homing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_homing_ms (r_homing_ms),
        .i_edge_seen (w_edge_seen),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_arm_cmd        <= w_res.arm;
            o_barrier_cmd    <= w_res.bar;
            o_rod_cmd        <= w_res.rod;
            o_edge_flags     <= w_edge_next;
            o_homing_running <= w_res.running;
            o_elapsed_ms     <= w_res.elapsed;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire
